// ----- rtl/pwb_pkg.sv -----
// Shared types and constants for the perspective warp block.
// No dependencies; used by rtl/perspective_warp_bilinear.sv.
`default_nettype none

package pwb_pkg;

   localparam int COORD_W  = 12;
   localparam int CHAN_W   = 8;
   localparam int PIX_W    = 3 * CHAN_W;
   localparam int COEF_W   = 32;
   localparam int CSR_IDX_W = 3;
   localparam int NUM_COEF = 8;

   localparam int SRC_WIDTH_DEF  = 512;
   localparam int SRC_HEIGHT_DEF = 512;
   localparam int FRAC_BITS_DEF  = 8;

   localparam int EDGE_LO  = 2;
   localparam int EDGE_HI  = 3;
   localparam int INT_BITS = 14;
   localparam int D_BIAS   = 1 << 24;

   // coefficient times zero-extended coordinate, sum of three, magnitude
   localparam int PROD_W = COEF_W + COORD_W + 1;
   localparam int SUM_W  = PROD_W + 1;
   localparam int MAG_W  = SUM_W - 1;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_WARP = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_XX = 3'd0,
      CSR_COEF_XY = 3'd1,
      CSR_COEF_X0 = 3'd2,
      CSR_COEF_YX = 3'd3,
      CSR_COEF_YY = 3'd4,
      CSR_COEF_Y0 = 3'd5,
      CSR_COEF_WX = 3'd6,
      CSR_COEF_WY = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic               valid;
      logic               cmd;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [PIX_W-1:0]   pix;
      logic               skip;
   } side_type;

   function automatic logic [COEF_W-1:0] coef_reset(input csr_index_type idx);
      logic [COEF_W-1:0] val;
      case (idx)
         CSR_COEF_XX: val = 32'h0001_0000;
         CSR_COEF_YY: val = 32'h0001_0000;
         default:     val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/perspective_warp_bilinear.sv -----
// Inverse perspective warp with bilinear sampling over a banked frame store.
// Depends on rtl/pwb_pkg.sv.
//
//   channel | direction | handshake           | carries
//   req     | in        | req_valid/req_ready | cmd, position, load pixel
//   rsp     | out       | rsp_valid/rsp_ready | inside flag, three channels
//   csr     | in        | csr_wr_en           | coefficient index and data
//
// One item per cycle while rsp is not stalled; a warp result is computed by the
// one-bit-per-stage divider pipeline (22 + FRAC_BITS steps).
// Loads write the store in the same stage where warps read it, so order holds.
// Synchronous reset restores identity coefficients and clears stage valids;
// the store is not cleared. req_ready is low during reset.
// A stalled rsp freezes the whole pipeline and req_ready drops.
`default_nettype none

module perspective_warp_bilinear #(
   parameter int SRC_WIDTH  = pwb_pkg::SRC_WIDTH_DEF,
   parameter int SRC_HEIGHT = pwb_pkg::SRC_HEIGHT_DEF,
   parameter int FRAC_BITS  = pwb_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_cmd,
   input  logic [pwb_pkg::COORD_W-1:0]       req_pos_x,
   input  logic [pwb_pkg::COORD_W-1:0]       req_pos_y,
   input  logic [pwb_pkg::CHAN_W-1:0]        req_chan0_in,
   input  logic [pwb_pkg::CHAN_W-1:0]        req_chan1_in,
   input  logic [pwb_pkg::CHAN_W-1:0]        req_chan2_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_inside_res,
   output logic [pwb_pkg::CHAN_W-1:0]        rsp_chan0_out,
   output logic [pwb_pkg::CHAN_W-1:0]        rsp_chan1_out,
   output logic [pwb_pkg::CHAN_W-1:0]        rsp_chan2_out,
   input  logic                              csr_wr_en,
   input  logic [pwb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pwb_pkg::COEF_W-1:0]        csr_wdata
);

   localparam int SHIFT   = 8 + FRAC_BITS;
   localparam int QW      = pwb_pkg::INT_BITS + SHIFT;
   localparam int IB      = pwb_pkg::INT_BITS;
   localparam int MAG_W   = pwb_pkg::MAG_W;
   localparam int SUM_W   = pwb_pkg::SUM_W;
   localparam int PROD_W  = pwb_pkg::PROD_W;
   localparam int CW      = pwb_pkg::COORD_W;
   localparam int CH_W    = pwb_pkg::CHAN_W;
   localparam int ONE_W   = FRAC_BITS + 1;
   localparam int WT_W    = 2 * FRAC_BITS + 1;
   localparam int PR_W    = CH_W + WT_W;
   localparam int ACC_W   = PR_W + 2;
   localparam int HALF_W  = (SRC_WIDTH + 1) / 2;
   localparam int HALF_H  = (SRC_HEIGHT + 1) / 2;
   localparam int BANK_DEPTH = HALF_W * HALF_H;
   localparam int AW      = $clog2(BANK_DEPTH);

   localparam logic [QW-1:0] X_LO = QW'(pwb_pkg::EDGE_LO << FRAC_BITS);
   localparam logic [QW-1:0] Y_LO = QW'(pwb_pkg::EDGE_LO << FRAC_BITS);
   localparam logic [QW-1:0] X_HI = QW'((SRC_WIDTH - pwb_pkg::EDGE_HI) << FRAC_BITS);
   localparam logic [QW-1:0] Y_HI = QW'((SRC_HEIGHT - pwb_pkg::EDGE_HI) << FRAC_BITS);
   localparam logic [CW:0]   W_LIM = (CW+1)'(SRC_WIDTH);
   localparam logic [CW:0]   H_LIM = (CW+1)'(SRC_HEIGHT);
   localparam logic [AW-1:0] HALF_W_C = AW'(HALF_W);
   localparam logic [ONE_W-1:0] ONE_C = ONE_W'(1) << FRAC_BITS;

   logic adv;

   // ---------------- coefficients
   logic [pwb_pkg::COEF_W-1:0] coef_ff [pwb_pkg::NUM_COEF];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pwb_pkg::NUM_COEF; i++) begin
            coef_ff[i] <= pwb_pkg::coef_reset(pwb_pkg::csr_index_type'(i));
         end
      end else if (csr_wr_en) begin
         coef_ff[csr_index] <= csr_wdata;
      end
   end

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv && !reset;

   // ---------------- stage 1: products
   pwb_pkg::side_type        s1_side_ff, s1_side_in;
   logic signed [PROD_W-1:0] s1_prod_ff [6];
   logic signed [PROD_W-1:0] s1_prod_in [6];
   logic signed [CW:0]       req_xs, req_ys;

   always_comb begin
      req_xs = $signed({1'b0, req_pos_x});
      req_ys = $signed({1'b0, req_pos_y});
      s1_side_in.valid = req_valid;
      s1_side_in.cmd   = req_cmd;
      s1_side_in.pos_x = req_pos_x;
      s1_side_in.pos_y = req_pos_y;
      s1_side_in.pix   = {req_chan2_in, req_chan1_in, req_chan0_in};
      s1_side_in.skip  = 1'b0;
      s1_prod_in[0] = $signed(coef_ff[pwb_pkg::CSR_COEF_XX]) * req_xs;
      s1_prod_in[1] = $signed(coef_ff[pwb_pkg::CSR_COEF_XY]) * req_ys;
      s1_prod_in[2] = $signed(coef_ff[pwb_pkg::CSR_COEF_YX]) * req_xs;
      s1_prod_in[3] = $signed(coef_ff[pwb_pkg::CSR_COEF_YY]) * req_ys;
      s1_prod_in[4] = $signed(coef_ff[pwb_pkg::CSR_COEF_WX]) * req_xs;
      s1_prod_in[5] = $signed(coef_ff[pwb_pkg::CSR_COEF_WY]) * req_ys;
   end

   // ---------------- stage 2: sums
   pwb_pkg::side_type       s2_side_ff;
   logic signed [SUM_W-1:0] s2_nx_ff, s2_ny_ff, s2_d_ff;
   logic signed [SUM_W-1:0] s2_nx_in, s2_ny_in, s2_d_in;

   always_comb begin
      s2_nx_in = SUM_W'(s1_prod_ff[0]) + SUM_W'(s1_prod_ff[1])
               + SUM_W'($signed(coef_ff[pwb_pkg::CSR_COEF_X0]));
      s2_ny_in = SUM_W'(s1_prod_ff[2]) + SUM_W'(s1_prod_ff[3])
               + SUM_W'($signed(coef_ff[pwb_pkg::CSR_COEF_Y0]));
      s2_d_in  = SUM_W'(s1_prod_ff[4]) + SUM_W'(s1_prod_ff[5])
               + SUM_W'(pwb_pkg::D_BIAS);
   end

   // ---------------- divider pipeline, entry at index 0
   pwb_pkg::side_type dv_side_ff [0:QW];
   pwb_pkg::side_type dv_side_in [0:QW];
   logic [MAG_W-1:0]  dv_ud_ff [0:QW];
   logic [MAG_W-1:0]  dv_ud_in [0:QW];
   logic [MAG_W-1:0]  dv_rx_ff [0:QW];
   logic [MAG_W-1:0]  dv_rx_in [0:QW];
   logic [MAG_W-1:0]  dv_ry_ff [0:QW];
   logic [MAG_W-1:0]  dv_ry_in [0:QW];
   logic [QW-1:0]     dv_qx_ff [0:QW];
   logic [QW-1:0]     dv_qx_in [0:QW];
   logic [QW-1:0]     dv_qy_ff [0:QW];
   logic [QW-1:0]     dv_qy_in [0:QW];
   logic [IB-1:0]     dv_lx_ff [0:QW];
   logic [IB-1:0]     dv_lx_in [0:QW];
   logic [IB-1:0]     dv_ly_ff [0:QW];
   logic [IB-1:0]     dv_ly_in [0:QW];

   logic             sgn_x, sgn_y, sgn_d;
   logic [MAG_W-1:0] mag_x, mag_y, mag_d;
   logic             ovf_x, ovf_y;
   pwb_pkg::side_type entry_side;

   assign sgn_x = s2_nx_ff[SUM_W-1];
   assign sgn_y = s2_ny_ff[SUM_W-1];
   assign sgn_d = s2_d_ff[SUM_W-1];
   assign mag_x = MAG_W'(sgn_x ? -s2_nx_ff : s2_nx_ff);
   assign mag_y = MAG_W'(sgn_y ? -s2_ny_ff : s2_ny_ff);
   assign mag_d = MAG_W'(sgn_d ? -s2_d_ff : s2_d_ff);
   // integer part of the quotient reaches the limit
   assign ovf_x = (mag_x >> IB) >= mag_d;
   assign ovf_y = (mag_y >> IB) >= mag_d;

   // negative ratios land at or below zero and fall outside the margin anyway
   always_comb begin
      entry_side      = s2_side_ff;
      entry_side.skip = (mag_d == '0) || (sgn_x != sgn_d) || (sgn_y != sgn_d)
                        || ovf_x || ovf_y;
   end

   assign dv_side_in[0] = entry_side;
   assign dv_ud_in[0]   = mag_d;
   assign dv_rx_in[0]   = mag_x >> IB;
   assign dv_ry_in[0]   = mag_y >> IB;
   assign dv_qx_in[0]   = '0;
   assign dv_qy_in[0]   = '0;
   assign dv_lx_in[0]   = mag_x[IB-1:0];
   assign dv_ly_in[0]   = mag_y[IB-1:0];

   for (genvar j = 0; j < QW; j++) begin : g_div
      logic [MAG_W:0] tx, ty;
      logic           gex, gey;
      assign tx  = {dv_rx_ff[j], dv_lx_ff[j][IB-1]};
      assign ty  = {dv_ry_ff[j], dv_ly_ff[j][IB-1]};
      assign gex = tx >= {1'b0, dv_ud_ff[j]};
      assign gey = ty >= {1'b0, dv_ud_ff[j]};
      assign dv_rx_in[j+1] = gex ? MAG_W'(tx - {1'b0, dv_ud_ff[j]}) : tx[MAG_W-1:0];
      assign dv_ry_in[j+1] = gey ? MAG_W'(ty - {1'b0, dv_ud_ff[j]}) : ty[MAG_W-1:0];
      assign dv_qx_in[j+1] = {dv_qx_ff[j][QW-2:0], gex};
      assign dv_qy_in[j+1] = {dv_qy_ff[j][QW-2:0], gey};
      assign dv_lx_in[j+1] = {dv_lx_ff[j][IB-2:0], 1'b0};
      assign dv_ly_in[j+1] = {dv_ly_ff[j][IB-2:0], 1'b0};
      assign dv_side_in[j+1] = dv_side_ff[j];
      assign dv_ud_in[j+1]   = dv_ud_ff[j];
   end

   // ---------------- stage B: bounds, addresses
   pwb_pkg::side_type b_side_ff, b_side_in;
   logic              b_inside_ff, b_inside_in;
   logic [AW-1:0]     b_addr_ff [4];
   logic [AW-1:0]     b_addr_in [4];
   logic [3:0]        b_we_ff, b_we_in;
   logic [1:0]        b_par_ff, b_par_in;
   logic [FRAC_BITS-1:0] b_fx_ff, b_fx_in, b_fy_ff, b_fy_in;

   logic [QW-1:0] px, py;
   logic [CW-1:0] bx, by;
   logic [CW:0]   row_sel, col_sel;
   logic          in_frame;

   always_comb begin
      px = dv_qx_ff[QW];
      py = dv_qy_ff[QW];
      b_side_in   = dv_side_ff[QW];
      b_inside_in = dv_side_ff[QW].valid && (dv_side_ff[QW].cmd == pwb_pkg::CMD_WARP)
                    && !dv_side_ff[QW].skip
                    && (px >= X_LO) && (px <= X_HI) && (py >= Y_LO) && (py <= Y_HI);
      b_fx_in = px[FRAC_BITS-1:0];
      b_fy_in = py[FRAC_BITS-1:0];
      if (dv_side_ff[QW].cmd == pwb_pkg::CMD_LOAD) begin
         bx = dv_side_ff[QW].pos_x;
         by = dv_side_ff[QW].pos_y;
      end else begin
         bx = CW'(px >> FRAC_BITS);
         by = CW'(py >> FRAC_BITS);
      end
      b_par_in = {by[0], bx[0]};
      in_frame = ({1'b0, dv_side_ff[QW].pos_x} < W_LIM)
                 && ({1'b0, dv_side_ff[QW].pos_y} < H_LIM);
      for (int b = 0; b < 4; b++) begin
         row_sel = {1'b0, by} + (CW+1)'(by[0] != b[1]);
         col_sel = {1'b0, bx} + (CW+1)'(bx[0] != b[0]);
         b_addr_in[b] = AW'(row_sel[CW:1]) * HALF_W_C + AW'(col_sel[CW:1]);
         b_we_in[b]   = dv_side_ff[QW].valid && (dv_side_ff[QW].cmd == pwb_pkg::CMD_LOAD)
                        && in_frame && (b_par_in == 2'(b));
      end
   end

   // ---------------- stage M: banked frame store, weights
   logic [pwb_pkg::PIX_W-1:0] bank_mem [4][BANK_DEPTH];
   logic [pwb_pkg::PIX_W-1:0] m_rd_ff [4];
   logic                      m_warp_ff, m_warp_in;
   logic                      m_inside_ff;
   logic [1:0]                m_par_ff;
   logic [WT_W-1:0]           m_w_ff [4];
   logic [WT_W-1:0]           m_w_in [4];
   logic [ONE_W-1:0]          ox, oy;

   always_comb begin
      m_warp_in = b_side_ff.valid && (b_side_ff.cmd == pwb_pkg::CMD_WARP);
      ox = ONE_C - ONE_W'(b_fx_ff);
      oy = ONE_C - ONE_W'(b_fy_ff);
      m_w_in[0] = WT_W'(ox) * WT_W'(oy);
      m_w_in[1] = WT_W'(b_fx_ff) * WT_W'(oy);
      m_w_in[2] = WT_W'(ox) * WT_W'(b_fy_ff);
      m_w_in[3] = WT_W'(b_fx_ff) * WT_W'(b_fy_ff);
   end

   for (genvar b = 0; b < 4; b++) begin : g_bank
      always_ff @(posedge clock) begin
         if (adv) begin
            if (b_we_ff[b]) begin
               bank_mem[b][b_addr_ff[b]] <= b_side_ff.pix;
            end
            m_rd_ff[b] <= bank_mem[b][b_addr_ff[b]];
         end
      end
   end

   // ---------------- stage P: channel products
   logic [PR_W-1:0] p_prod_ff [12];
   logic [PR_W-1:0] p_prod_in [12];
   logic            p_warp_ff, p_inside_ff;
   logic [pwb_pkg::PIX_W-1:0] nb_pix;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         nb_pix = m_rd_ff[m_par_ff ^ 2'(k)];
         for (int c = 0; c < 3; c++) begin
            p_prod_in[c*4+k] = PR_W'(nb_pix[c*CH_W +: CH_W]) * PR_W'(m_w_ff[k]);
         end
      end
   end

   // ---------------- stage O: sums, output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_inside_ff, rsp_inside_in;
   logic [CH_W-1:0]   rsp_chan_ff [3];
   logic [CH_W-1:0]   rsp_chan_in [3];
   logic [ACC_W-1:0]  acc;

   always_comb begin
      rsp_valid_in  = p_warp_ff;
      rsp_inside_in = p_inside_ff;
      for (int c = 0; c < 3; c++) begin
         acc = ACC_W'(p_prod_ff[c*4]) + ACC_W'(p_prod_ff[c*4+1])
             + ACC_W'(p_prod_ff[c*4+2]) + ACC_W'(p_prod_ff[c*4+3]);
         rsp_chan_in[c] = p_inside_ff ? acc[2*FRAC_BITS +: CH_W] : '0;
      end
   end

   // ---------------- pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_side_ff.valid <= 1'b0;
         s2_side_ff.valid <= 1'b0;
         for (int j = 0; j <= QW; j++) begin
            dv_side_ff[j].valid <= 1'b0;
         end
         b_side_ff.valid <= 1'b0;
         b_inside_ff     <= 1'b0;
         b_we_ff         <= '0;
         m_warp_ff       <= 1'b0;
         m_inside_ff     <= 1'b0;
         p_warp_ff       <= 1'b0;
         p_inside_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         rsp_inside_ff   <= 1'b0;
      end else if (adv) begin
         s1_side_ff <= s1_side_in;
         s2_side_ff <= s1_side_ff;
         for (int j = 0; j <= QW; j++) begin
            dv_side_ff[j] <= dv_side_in[j];
         end
         b_side_ff     <= b_side_in;
         b_inside_ff   <= b_inside_in;
         b_we_ff       <= b_we_in;
         m_warp_ff     <= m_warp_in;
         m_inside_ff   <= b_inside_ff;
         p_warp_ff     <= m_warp_ff;
         p_inside_ff   <= m_inside_ff;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_inside_ff <= rsp_inside_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_prod_ff <= s1_prod_in;
         s2_nx_ff   <= s2_nx_in;
         s2_ny_ff   <= s2_ny_in;
         s2_d_ff    <= s2_d_in;
         for (int j = 0; j <= QW; j++) begin
            dv_ud_ff[j] <= dv_ud_in[j];
            dv_rx_ff[j] <= dv_rx_in[j];
            dv_ry_ff[j] <= dv_ry_in[j];
            dv_qx_ff[j] <= dv_qx_in[j];
            dv_qy_ff[j] <= dv_qy_in[j];
            dv_lx_ff[j] <= dv_lx_in[j];
            dv_ly_ff[j] <= dv_ly_in[j];
         end
         b_addr_ff   <= b_addr_in;
         b_par_ff    <= b_par_in;
         b_fx_ff     <= b_fx_in;
         b_fy_ff     <= b_fy_in;
         m_par_ff    <= b_par_ff;
         m_w_ff      <= m_w_in;
         p_prod_ff   <= p_prod_in;
         rsp_chan_ff <= rsp_chan_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;
   assign rsp_chan0_out  = rsp_chan_ff[0];
   assign rsp_chan1_out  = rsp_chan_ff[1];
   assign rsp_chan2_out  = rsp_chan_ff[2];

endmodule

`default_nettype wire

// ----- sim/tb_perspective_warp_bilinear.sv -----
// Self-checking testbench for perspective_warp_bilinear: directed table, then random phases.
// Depends on rtl/pwb_pkg.sv and rtl/perspective_warp_bilinear.sv; checks against an inline predictor.
`default_nettype none

module tb_perspective_warp_bilinear;

   localparam int SW          = 512;
   localparam int SH          = 512;
   localparam int FB          = 8;
   localparam int LATENCY     = 29 + FB;
   localparam int WATCH_LIMIT = 4000;
   localparam int REGION      = 14;
   localparam int PHASE_ITEMS = 90;

   typedef struct {
      logic       sampled;
      logic [7:0] c0, c1, c2;
   } pixel_result_type;

   typedef struct {
      logic        cmd;
      int          x, y;
      logic [7:0]  c0, c1, c2;
      bit          typed;
      logic        ins;
      logic [7:0]  e0, e1, e2;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_cmd = pwb_pkg::CMD_LOAD;
   logic [pwb_pkg::COORD_W-1:0] req_pos_x = '0, req_pos_y = '0;
   logic [pwb_pkg::CHAN_W-1:0] req_chan0_in = '0, req_chan1_in = '0, req_chan2_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_inside_res;
   logic [pwb_pkg::CHAN_W-1:0] rsp_chan0_out, rsp_chan1_out, rsp_chan2_out;
   logic csr_wr_en = 1'b0;
   logic [pwb_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [pwb_pkg::COEF_W-1:0] csr_wdata = '0;

   logic signed [31:0] coef [pwb_pkg::NUM_COEF];
   logic [23:0] frame_mem [SW*SH];
   bit frame_written [SW*SH];
   pixel_result_type expected_px [$];
   bit calm = 0;
   int errors = 0, n_loads = 0, n_warps = 0, n_inside = 0, idle_cycles = 0;

   perspective_warp_bilinear dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic bit div_pos(input longint num, input longint den,
                                  output longint unsigned pos);
      bit neg;
      longint unsigned un, ud, q, r;
      neg = (num < 0) != (den < 0);
      un = num < 0 ? -num : num;
      ud = den < 0 ? -den : den;
      pos = 0;
      if (ud == 0) return 0;
      q = un / ud;
      r = un % ud;
      if (q >= (1 << pwb_pkg::INT_BITS)) return 0;
      for (int i = 0; i < 8 + FB; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= ud) begin
            r -= ud;
            q |= 1;
         end
      end
      if (neg && q != 0) return 0;
      pos = q;
      return 1;
   endfunction

   function automatic bit edge_ok(input longint unsigned p, input int size);
      return p >= (pwb_pkg::EDGE_LO << FB) &&
             p + (pwb_pkg::EDGE_HI << FB) <= (longint'(size) << FB);
   endfunction

   // reads_ok drops when the sample would touch a pixel never loaded
   function automatic pixel_result_type warp_pixel(input int x, input int y,
                                                   output bit reads_ok);
      pixel_result_type res;
      longint nx, ny, d;
      longint unsigned px, py, fx, fy, one, acc;
      longint unsigned w [4];
      int idx [4];
      int ix, iy;
      res = '{1'b0, 8'd0, 8'd0, 8'd0};
      reads_ok = 1;
      nx = longint'(coef[pwb_pkg::CSR_COEF_XX]) * x + longint'(coef[pwb_pkg::CSR_COEF_XY]) * y
           + longint'(coef[pwb_pkg::CSR_COEF_X0]);
      ny = longint'(coef[pwb_pkg::CSR_COEF_YX]) * x + longint'(coef[pwb_pkg::CSR_COEF_YY]) * y
           + longint'(coef[pwb_pkg::CSR_COEF_Y0]);
      d  = longint'(coef[pwb_pkg::CSR_COEF_WX]) * x + longint'(coef[pwb_pkg::CSR_COEF_WY]) * y
           + pwb_pkg::D_BIAS;
      if (!div_pos(nx, d, px) || !div_pos(ny, d, py)) return res;
      if (!edge_ok(px, SW) || !edge_ok(py, SH)) return res;
      one = 1 << FB;
      fx = px & (one - 1);
      fy = py & (one - 1);
      ix = int'(px >> FB);
      iy = int'(py >> FB);
      w[0] = (one - fx) * (one - fy);
      w[1] = fx * (one - fy);
      w[2] = (one - fx) * fy;
      w[3] = fx * fy;
      idx[0] = iy * SW + ix;
      idx[1] = idx[0] + 1;
      idx[2] = idx[0] + SW;
      idx[3] = idx[2] + 1;
      for (int k = 0; k < 4; k++)
         if (!frame_written[idx[k]]) reads_ok = 0;
      res.sampled = 1'b1;
      for (int c = 0; c < 3; c++) begin
         acc = 0;
         for (int k = 0; k < 4; k++)
            acc += longint'((frame_mem[idx[k]] >> (8 * c)) & 8'hFF) * w[k];
         case (c)
            0: res.c0 = 8'((acc >> (2 * FB)) & 8'hFF);
            1: res.c1 = 8'((acc >> (2 * FB)) & 8'hFF);
            default: res.c2 = 8'((acc >> (2 * FB)) & 8'hFF);
         endcase
      end
      return res;
   endfunction

   task automatic report(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
   endtask

   task automatic send_item(input stim_row_type r);
      bit ok;
      pixel_result_type p;
      if (!calm && $urandom_range(0, 99) < 8) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_cmd      <= r.cmd;
      req_pos_x    <= pwb_pkg::COORD_W'(r.x);
      req_pos_y    <= pwb_pkg::COORD_W'(r.y);
      req_chan0_in <= r.c0;
      req_chan1_in <= r.c1;
      req_chan2_in <= r.c2;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (r.cmd == pwb_pkg::CMD_LOAD) begin
         n_loads++;
         if (r.x < SW && r.y < SH) begin
            frame_mem[r.y * SW + r.x] = {r.c2, r.c1, r.c0};
            frame_written[r.y * SW + r.x] = 1;
         end
      end else begin
         n_warps++;
         p = warp_pixel(r.x, r.y, ok);
         if (r.typed) p = '{r.ins, r.e0, r.e1, r.e2};
         expected_px.insert(expected_px.size(), p);
      end
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (expected_px.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_coef(input pwb_pkg::csr_index_type idx, input logic [31:0] v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      coef[idx] = v;
   endtask

   task automatic set_coefs(input logic [31:0] v [pwb_pkg::NUM_COEF]);
      write_coef(pwb_pkg::CSR_COEF_XX, v[0]);
      write_coef(pwb_pkg::CSR_COEF_XY, v[1]);
      write_coef(pwb_pkg::CSR_COEF_X0, v[2]);
      write_coef(pwb_pkg::CSR_COEF_YX, v[3]);
      write_coef(pwb_pkg::CSR_COEF_YY, v[4]);
      write_coef(pwb_pkg::CSR_COEF_Y0, v[5]);
      write_coef(pwb_pkg::CSR_COEF_WX, v[6]);
      write_coef(pwb_pkg::CSR_COEF_WY, v[7]);
      csr_wr_en <= 1'b0;
   endtask

   function automatic stim_row_type random_row();
      stim_row_type r;
      bit ok;
      pixel_result_type p;
      r = '{pwb_pkg::CMD_LOAD, 0, 0, 8'($urandom), 8'($urandom), 8'($urandom),
            0, 1'b0, 0, 0, 0};
      if ($urandom_range(0, 99) < 40) begin
         if ($urandom_range(0, 9) == 0) begin
            r.x = $urandom_range(0, 4095);
            r.y = $urandom_range(0, 4095);
         end else begin
            r.x = $urandom_range(0, REGION - 1);
            r.y = $urandom_range(0, REGION - 1);
         end
         return r;
      end
      r.cmd = pwb_pkg::CMD_WARP;
      for (int t = 0; t < 20; t++) begin
         if ($urandom_range(0, 3) == 0) begin
            r.x = $urandom_range(0, 4095);
            r.y = $urandom_range(0, 4095);
         end else begin
            r.x = $urandom_range(0, 15);
            r.y = $urandom_range(0, 15);
         end
         p = warp_pixel(r.x, r.y, ok);
         if (ok) return r;
      end
      // fallback: a load outside the frame, which the block drops
      r.cmd = pwb_pkg::CMD_LOAD;
      r.x = SW + $urandom_range(0, 100);
      return r;
   endfunction

   always @(posedge clock) rsp_ready <= calm || ($urandom_range(0, 99) >= 8);

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_px.size() == 0) begin
            report("result transfer with nothing expected");
         end else begin
            pixel_result_type e;
            e = expected_px.pop_front();
            if (rsp_inside_res !== e.sampled || rsp_chan0_out !== e.c0 ||
                rsp_chan1_out !== e.c1 || rsp_chan2_out !== e.c2)
               report($sformatf("got %b %h %h %h, want %b %h %h %h", rsp_inside_res,
                      rsp_chan0_out, rsp_chan1_out, rsp_chan2_out,
                      e.sampled, e.c0, e.c1, e.c2));
            if (rsp_inside_res === 1'b1) n_inside++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == WATCH_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCH_LIMIT);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      stim_row_type dir_tab [18];
      logic [31:0] cfg [pwb_pkg::NUM_COEF];
      for (int i = 0; i < pwb_pkg::NUM_COEF; i++)
         coef[i] = pwb_pkg::coef_reset(pwb_pkg::csr_index_type'(i));
      dir_tab = '{
         '{pwb_pkg::CMD_LOAD, 2, 2, 8'hFF, 8'h00, 8'hA5, 0, 1'b0, 0, 0, 0},
         '{pwb_pkg::CMD_LOAD, 3, 2, 8'h10, 8'h20, 8'h30, 0, 1'b0, 0, 0, 0},
         '{pwb_pkg::CMD_LOAD, 2, 3, 8'h40, 8'h50, 8'h60, 0, 1'b0, 0, 0, 0},
         '{pwb_pkg::CMD_LOAD, 3, 3, 8'h70, 8'h80, 8'h90, 0, 1'b0, 0, 0, 0},
         '{pwb_pkg::CMD_WARP, 2, 2, 0, 0, 0, 1, 1'b1, 8'hFF, 8'h00, 8'hA5},
         '{pwb_pkg::CMD_WARP, 3, 3, 0, 0, 0, 1, 1'b1, 8'h70, 8'h80, 8'h90},
         '{pwb_pkg::CMD_WARP, 0, 0, 0, 0, 0, 1, 1'b0, 0, 0, 0},
         '{pwb_pkg::CMD_WARP, 1, 5, 0, 0, 0, 1, 1'b0, 0, 0, 0},
         '{pwb_pkg::CMD_WARP, 5, 1, 0, 0, 0, 1, 1'b0, 0, 0, 0},
         '{pwb_pkg::CMD_WARP, 510, 5, 0, 0, 0, 1, 1'b0, 0, 0, 0},
         '{pwb_pkg::CMD_WARP, 5, 510, 0, 0, 0, 1, 1'b0, 0, 0, 0},
         '{pwb_pkg::CMD_WARP, 4095, 4095, 0, 0, 0, 1, 1'b0, 0, 0, 0},
         '{pwb_pkg::CMD_WARP, 4095, 0, 0, 0, 0, 1, 1'b0, 0, 0, 0},
         '{pwb_pkg::CMD_LOAD, 4095, 4095, 8'hFF, 8'hFF, 8'hFF, 0, 1'b0, 0, 0, 0},
         '{pwb_pkg::CMD_LOAD, 512, 7, 8'hFF, 8'hFF, 8'hFF, 0, 1'b0, 0, 0, 0},
         '{pwb_pkg::CMD_LOAD, 0, 0, 8'h00, 8'h00, 8'h00, 0, 1'b0, 0, 0, 0},
         '{pwb_pkg::CMD_WARP, 6, 7, 0, 0, 0, 0, 1'b0, 0, 0, 0},
         '{pwb_pkg::CMD_WARP, 10, 10, 0, 0, 0, 0, 1'b0, 0, 0, 0}};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill a small source window so warps never sample unloaded pixels
      for (int y = 0; y < REGION; y++)
         for (int x = 0; x < REGION; x++)
            send_item('{pwb_pkg::CMD_LOAD, x, y, 8'($urandom), 8'($urandom), 8'($urandom),
                        0, 1'b0, 0, 0, 0});
      foreach (dir_tab[i]) send_item(dir_tab[i]);

      for (int ph = 0; ph < 6; ph++) begin
         drain();
         case (ph)
            0: cfg = '{32'h8000, 0, 32'h20000, 0, 32'h8000, 32'h20000, 32'h1000, 32'h800};
            1: cfg = '{default: 32'h7FFF_FFFF};
            2: cfg = '{default: 32'h8000_0000};
            3: cfg = '{32'h10000, 0, 32'h30000, 0, 32'h10000, 32'h30000, 32'hFF00_0000, 0};
            default: begin
               cfg[0] = $urandom_range(32'h4000, 32'h18000);
               cfg[1] = 32'($signed($urandom_range(0, 32'h4000)) - 32'sh2000);
               cfg[2] = $urandom_range(0, 32'h60000);
               cfg[3] = 32'($signed($urandom_range(0, 32'h4000)) - 32'sh2000);
               cfg[4] = $urandom_range(32'h4000, 32'h18000);
               cfg[5] = $urandom_range(0, 32'h60000);
               cfg[6] = 32'($signed($urandom_range(0, 32'h4000)) - 32'sh2000);
               cfg[7] = 32'($signed($urandom_range(0, 32'h4000)) - 32'sh2000);
            end
         endcase
         set_coefs(cfg);
         if (ph == 3) send_item('{pwb_pkg::CMD_WARP, 1, 4, 0, 0, 0, 0, 1'b0, 0, 0, 0});
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            calm = (ph == 4 && i < 60);
            send_item(random_row());
         end
         calm = 0;
      end
      drain();

      $display("covered %0d loads and %0d warps over 7 coefficient settings, %0d sampled",
               n_loads, n_warps, n_inside);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", errors);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
